>>> rtl/tlwh_pkg.sv
// Shared types and constants of the two-lane word hash.
// Holds the seed, round and finalization constants, the byte mask helper and
// the command and status bundles exchanged between controller and datapath.
`default_nettype none

package tlwh_pkg;

  localparam logic [31:0] SEED_A = 32'h9e37_79b9;
  localparam logic [31:0] SEED_B = 32'h85eb_ca6b;
  localparam logic [31:0] MUL_A  = 32'h9e37_79b1;
  localparam logic [31:0] MUL_B  = 32'hc2b2_ae35;
  localparam logic [31:0] FIN_A  = 32'h85eb_ca6b;
  localparam logic [31:0] FIN_B  = 32'h27d4_eb2f;

  localparam int WORD_BITS   = 32;
  localparam int LENGTH_BITS = 12;
  localparam int COUNT_BITS  = 3;
  localparam int KEY_BITS    = 64;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture request, seed lanes when first
    logic mix;       // one round with the captured word
    logic mix_zero;  // one round with a zero word
    logic fin;       // finalization multiply
    logic emit;      // load the result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;      // captured request ends the message
    logic full_word; // captured request carries four or more bytes
    logic out_free;  // result register can take a new key
  } status_t;

  // Zero the bytes above the valid count; counts above four keep all bytes.
  function automatic logic [WORD_BITS-1:0] mask_word(input logic [WORD_BITS-1:0] w,
                                                     input logic [COUNT_BITS-1:0] cnt);
    logic [WORD_BITS-1:0] m;
    begin
      m = w;
      if (!cnt[2]) begin
        case (cnt[1:0])
          2'd0:    m = '0;
          2'd1:    m = {24'b0, w[7:0]};
          2'd2:    m = {16'b0, w[15:0]};
          2'd3:    m = {8'b0, w[23:0]};
          default: m = w;
        endcase
      end
      return m;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/two_lane_word_hash_unit.sv
// Two-lane word hash, top level: joins controller and datapath.
// Depends on tlwh_pkg, tlwh_ctrl and tlwh_datapath.
//
// Hashes a byte message, streamed as little-endian 32-bit words, into a
// 64-bit key (lane A in bits 63..32, lane B in bits 31..0). A request with
// first set seeds both lanes from total_length; every request mixes its
// zero-padded word into both lanes. A request is first captured, then mixed
// in a round whose rotate-and-multiply on each lane runs through one 32x32
// multiplier per lane. A request with last set adds one more round when it
// carries four or more bytes, then a finalization multiply and the load of
// the key, and it waits longer while the previous key still waits unaccepted
// in the result register. The key waits in its own register; new requests
// are taken while it waits.
`default_nettype none

module two_lane_word_hash_unit
  import tlwh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   msg_valid,
  output logic                        msg_stall,
  input  wire logic                   first,
  input  wire logic [LENGTH_BITS-1:0] total_length,
  input  wire logic [WORD_BITS-1:0]   data_word,
  input  wire logic [COUNT_BITS-1:0]  byte_count,
  input  wire logic                   last,
  output logic                        key_valid,
  input  wire logic                   key_stall,
  output logic [KEY_BITS-1:0]         key_hash
);

  cmd_t    cmd;
  status_t status;

  tlwh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlwh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .first        (first),
    .total_length (total_length),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last         (last),
    .cmd          (cmd),
    .status       (status),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_hash     (key_hash)
  );

endmodule

`default_nettype wire

>>> rtl/tlwh_ctrl.sv
// Controller state machine of the two-lane word hash.
// Sequences capture, word rounds, tail round, finalization and emit.
// Depends on tlwh_pkg for the command and status bundles.
`default_nettype none

module tlwh_ctrl
  import tlwh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    msg_valid,
  output logic         msg_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MIX  = 5'b00010,
    ST_TAIL = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign msg_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        if (!status.last) begin
          state_next = ST_IDLE;
        end else if (status.full_word) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_TAIL: begin
        cmd.mix_zero = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit while result register occupied");

  a_tail_after_mix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAIL) |-> $past(state == ST_MIX))
    else $error("tail round not preceded by word round");

  a_load_then_mix: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_MIX))
    else $error("captured request not mixed next cycle");

endmodule

`default_nettype wire

>>> rtl/tlwh_datapath.sv
// Datapath of the two-lane word hash: lane registers, round multipliers,
// finalization multipliers and the result register.
// Depends on tlwh_pkg for constants, the byte mask and the control bundles.
`default_nettype none

module tlwh_datapath
  import tlwh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   first,
  input  wire logic [LENGTH_BITS-1:0] total_length,
  input  wire logic [WORD_BITS-1:0]   data_word,
  input  wire logic [COUNT_BITS-1:0]  byte_count,
  input  wire logic                   last,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  output logic                        key_valid,
  input  wire logic                   key_stall,
  output logic [KEY_BITS-1:0]         key_hash
);

  logic [WORD_BITS-1:0] lane_a;
  logic [WORD_BITS-1:0] lane_b;
  logic [WORD_BITS-1:0] word;
  logic                 word_last;
  logic                 word_full;
  logic [WORD_BITS-1:0] fin_a;
  logic [WORD_BITS-1:0] fin_b;

  logic [WORD_BITS-1:0] operand;
  logic [WORD_BITS-1:0] mix_a_in;
  logic [WORD_BITS-1:0] mix_b_in;
  logic [WORD_BITS-1:0] rot_a;
  logic [WORD_BITS-1:0] rot_b;
  logic [WORD_BITS-1:0] round_a;
  logic [WORD_BITS-1:0] round_b;
  logic [WORD_BITS-1:0] pre_a;
  logic [WORD_BITS-1:0] pre_b;
  logic [WORD_BITS-1:0] prod_a;
  logic [WORD_BITS-1:0] prod_b;
  logic [WORD_BITS-1:0] lane_a_seed;
  logic [WORD_BITS-1:0] lane_b_seed;

  assign operand  = cmd.mix_zero ? '0 : word;
  assign mix_a_in = lane_a ^ operand;
  assign mix_b_in = lane_b + operand;
  assign rot_a    = {mix_a_in[18:0], mix_a_in[31:19]};
  assign rot_b    = {mix_b_in[14:0], mix_b_in[31:15]};
  assign round_a  = rot_a * MUL_A;
  assign round_b  = rot_b * MUL_B;

  assign pre_a  = lane_a ^ (lane_a >> 16);
  assign pre_b  = lane_b ^ (lane_b >> 15);
  assign prod_a = pre_a * FIN_A;
  assign prod_b = pre_b * FIN_B;

  assign lane_a_seed = SEED_A ^ {{(WORD_BITS-LENGTH_BITS){1'b0}}, total_length};
  assign lane_b_seed = SEED_B + {{(WORD_BITS-LENGTH_BITS){1'b0}}, total_length};

  assign status.last      = word_last;
  assign status.full_word = word_full;
  assign status.out_free  = !key_valid || !key_stall;

  // Lanes: seed on capture of a first request, advance on each round.
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_a <= '0;
      lane_b <= '0;
    end else if (cmd.load && first) begin
      lane_a <= lane_a_seed;
      lane_b <= lane_b_seed;
    end else if (cmd.mix || cmd.mix_zero) begin
      lane_a <= round_a;
      lane_b <= round_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word      <= mask_word(data_word, byte_count);
      word_last <= last;
      word_full <= byte_count[2];
    end
    if (cmd.fin) begin
      fin_a <= prod_a;
      fin_b <= prod_b;
    end
    if (cmd.emit) begin
      key_hash <= {fin_a ^ (fin_a >> 13), fin_b ^ (fin_b >> 16)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (cmd.emit) begin
      key_valid <= 1'b1;
    end else if (!key_stall) begin
      key_valid <= 1'b0;
    end
  end

  a_emit_shows_key: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> key_valid)
    else $error("emitted key not presented");

endmodule

`default_nettype wire

>>> sim/two_lane_word_hash_checker.sv
// Scoreboard for the two-lane word hash: predicts the key of every message.
// Depends on tlwh_pkg; watches the request and key channels of the top level.
`timescale 1ns / 100ps
`default_nettype none

module two_lane_word_hash_checker
  import tlwh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   msg_valid,
  input  wire logic                   msg_stall,
  input  wire logic                   first,
  input  wire logic [LENGTH_BITS-1:0] total_length,
  input  wire logic [WORD_BITS-1:0]   data_word,
  input  wire logic [COUNT_BITS-1:0]  byte_count,
  input  wire logic                   last,
  input  wire logic                   key_valid,
  input  wire logic                   key_stall,
  input  wire logic [KEY_BITS-1:0]    key_hash,
  output int                          fail_count,
  output int                          keys_outstanding
);

  localparam int ROT_A = 13;
  localparam int ROT_B = 17;

  logic [2*WORD_BITS-1:0] lanes_q;
  logic [KEY_BITS-1:0]    keys_due[$];
  int                     fails;

  function automatic logic [WORD_BITS-1:0] spin_left(input logic [WORD_BITS-1:0] x,
                                                     input int n);
    return (x << n) | (x >> (WORD_BITS - n));
  endfunction

  function automatic logic [WORD_BITS-1:0] pad_word(input logic [WORD_BITS-1:0] w,
                                                    input logic [COUNT_BITS-1:0] cnt);
    logic [WORD_BITS-1:0] keep;
    if (cnt >= 4) return w;
    keep = (32'h1 << (8 * cnt)) - 32'h1;
    return w & keep;
  endfunction

  function automatic logic [2*WORD_BITS-1:0] mix_lanes(input logic [2*WORD_BITS-1:0] lanes,
                                                       input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    a = spin_left(lanes[2*WORD_BITS-1:WORD_BITS] ^ w, ROT_A) * MUL_A;
    b = lanes[WORD_BITS-1:0] + w;
    b = spin_left(b, ROT_B) * MUL_B;
    return {a, b};
  endfunction

  function automatic logic [KEY_BITS-1:0] seal_key(input logic [2*WORD_BITS-1:0] lanes);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    a = lanes[2*WORD_BITS-1:WORD_BITS];
    a = a ^ (a >> 16);
    a = a * FIN_A;
    a = a ^ (a >> 13);
    b = lanes[WORD_BITS-1:0];
    b = b ^ (b >> 15);
    b = b * FIN_B;
    b = b ^ (b >> 16);
    return {a, b};
  endfunction

  always @(posedge clk) begin : watch_channels
    logic [2*WORD_BITS-1:0] lanes;
    logic [KEY_BITS-1:0]    key;
    if (rst) begin
      lanes_q <= '0;
      keys_due.delete();
      fails = 0;
    end else begin
      if (msg_valid && !msg_stall) begin
        lanes = lanes_q;
        if (first) begin
          lanes = {SEED_A ^ WORD_BITS'(total_length), SEED_B + WORD_BITS'(total_length)};
        end
        lanes = mix_lanes(lanes, pad_word(data_word, byte_count));
        if (last && byte_count >= 4) begin
          lanes = mix_lanes(lanes, '0);
        end
        if (last) begin
          keys_due.push_back(seal_key(lanes));
        end
        lanes_q <= lanes;
      end
      if (key_valid && !key_stall) begin
        if (keys_due.size() == 0) begin
          fails++;
          $display("%0t: key_hash expected none actual %h", $time, key_hash);
        end else begin
          key = keys_due.pop_front();
          if (key_hash !== key) begin
            fails++;
            $display("%0t: key_hash expected %h actual %h", $time, key, key_hash);
          end
        end
      end
    end
    fail_count <= fails;
    keys_outstanding <= keys_due.size();
  end

endmodule

`default_nettype wire

>>> sim/two_lane_word_hash_unit_tb.sv
// Testbench top for two_lane_word_hash_unit: drives directed and random messages,
// stalls the key channel, and reports the verdict.
// Depends on tlwh_pkg, two_lane_word_hash_unit and two_lane_word_hash_checker.
`timescale 1ns / 100ps
`default_nettype none

module two_lane_word_hash_unit_tb;
  import tlwh_pkg::*;

  localparam int IDLE_PCT     = 35;
  localparam int RANDOM_REQS  = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;

  logic                   clk;
  logic                   rst;
  logic                   msg_valid;
  logic                   msg_stall;
  logic                   first;
  logic [LENGTH_BITS-1:0] total_length;
  logic [WORD_BITS-1:0]   data_word;
  logic [COUNT_BITS-1:0]  byte_count;
  logic                   last;
  logic                   key_valid;
  logic                   key_stall;
  logic [KEY_BITS-1:0]    key_hash;

  logic calm;
  logic hold_req;
  int   fail_count;
  int   keys_outstanding;

  two_lane_word_hash_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .first        (first),
    .total_length (total_length),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last         (last),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_hash     (key_hash)
  );

  two_lane_word_hash_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .msg_valid        (msg_valid),
    .msg_stall        (msg_stall),
    .first            (first),
    .total_length     (total_length),
    .data_word        (data_word),
    .byte_count       (byte_count),
    .last             (last),
    .key_valid        (key_valid),
    .key_stall        (key_stall),
    .key_hash         (key_hash),
    .fail_count       (fail_count),
    .keys_outstanding (keys_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_req(input logic f, input logic [LENGTH_BITS-1:0] len,
                          input logic [WORD_BITS-1:0] w, input logic [COUNT_BITS-1:0] cnt,
                          input logic l);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    first        <= f;
    total_length <= len;
    data_word    <= w;
    byte_count   <= cnt;
    last         <= l;
    msg_valid    <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
  endtask

  // Key receiver: random stalls, one long hold-off, a calm stretch without stalls.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    key_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        key_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        key_stall <= 1'b1;
      end else begin
        key_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((msg_valid && !msg_stall) || (key_valid && !key_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int sent;
    int len;
    int words;
    int cnt;
    int n;
    rst          <= 1'b1;
    msg_valid    <= 1'b0;
    first        <= 1'b0;
    total_length <= '0;
    data_word    <= '0;
    byte_count   <= '0;
    last         <= 1'b0;
    calm         <= 1'b0;
    hold_req     <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // no first request after reset: mix into zero lanes
    send_req(1'b0, 12'd0,    32'hdead_beef, 3'd4, 1'b0);
    send_req(1'b0, 12'd0,    32'hffff_ffff, 3'd2, 1'b1);
    // empty message, a single round with a zero word
    send_req(1'b1, 12'd0,    32'hffff_ffff, 3'd0, 1'b1);
    // message ends on a word boundary
    send_req(1'b1, 12'd4,    32'hffff_ffff, 3'd4, 1'b1);
    // short word before last, length mismatch
    send_req(1'b1, 12'd4095, 32'h0000_0000, 3'd4, 1'b0);
    send_req(1'b0, 12'd0,    32'h1234_5678, 3'd1, 1'b0);
    send_req(1'b0, 12'd4095, 32'ha5a5_a5a5, 3'd3, 1'b1);
    // continue after last without a new first
    send_req(1'b0, 12'd0,    32'hffff_ffff, 3'd4, 1'b1);
    // counts above four
    send_req(1'b1, 12'd2048, 32'h8000_0000, 3'd5, 1'b0);
    send_req(1'b0, 12'd0,    32'h0000_0001, 3'd6, 1'b0);
    send_req(1'b0, 12'd0,    32'hffff_ffff, 3'd7, 1'b1);
    // single-word messages, partial and full
    send_req(1'b1, 12'd3,    32'hffff_ffff, 3'd3, 1'b1);
    send_req(1'b1, 12'd1,    32'hffff_ff80, 3'd1, 1'b1);
    send_req(1'b1, 12'd2,    32'h7fff_ffff, 3'd2, 1'b1);
    send_req(1'b1, 12'd1,    32'h0102_0304, 3'd4, 1'b1);

    sent = 0;
    while (sent < RANDOM_REQS) begin
      calm     <= (sent >= 700 && sent < 900);
      hold_req <= (sent >= 300);
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 199) == 0) ? $urandom_range(512, 2048)
                                              : $urandom_range(0, 40);
        words = (len + 3) / 4;
        if (words == 0) words = 1;
        for (int i = 0; i < words; i++) begin
          cnt = (i == words - 1) ? len - 4 * i : 4;
          send_req(i == 0,
                   LENGTH_BITS'((i == 0) ? len : $urandom_range(0, 4095)),
                   $urandom, COUNT_BITS'(cnt), i == words - 1);
        end
        sent += words;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_req(1'($urandom_range(0, 1)), LENGTH_BITS'($urandom_range(0, 4095)),
                   $urandom, COUNT_BITS'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
        end
        sent += n;
      end
    end

    msg_valid <= 1'b0;
    @(posedge clk);
    while (keys_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && keys_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> two_lane_word_hash_unit.f
rtl/tlwh_pkg.sv
rtl/tlwh_ctrl.sv
rtl/tlwh_datapath.sv
rtl/two_lane_word_hash_unit.sv
sim/two_lane_word_hash_checker.sv
sim/two_lane_word_hash_unit_tb.sv
